// File: src/frd_pkg.sv
// frd_pkg: shared types and sequencer state codes for the fraction reducer.
// No dependencies; used by fraction_reduce_top.
`default_nettype none
package frd_pkg;

   typedef logic [2:0] state_type;

   localparam state_type ST_IDLE = 3'd0;
   localparam state_type ST_TWOS = 3'd1;
   localparam state_type ST_GCD  = 3'd2;
   localparam state_type ST_DIVN = 3'd3;
   localparam state_type ST_DIVD = 3'd4;

endpackage
`default_nettype wire

// File: src/frd_divider.sv
// frd_divider: restoring unsigned divider, one quotient bit per cycle.
// Standalone; instantiated by fraction_reduce_top.
`default_nettype none
module frd_divider #(
   parameter int VALUE_WIDTH = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire [VALUE_WIDTH-1:0]  dividend,
   input  wire [VALUE_WIDTH-1:0]  divisor,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] quotient
);

   localparam int CW = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   active_ff, active_in;
   logic                   done_ff, done_in;

   logic [VALUE_WIDTH:0]   shifted;
   logic [VALUE_WIDTH:0]   diff;
   logic                   take;

   always_comb begin
      shifted   = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      diff      = shifted - {1'b0, dsr_ff};
      take      = (shifted >= {1'b0, dsr_ff});
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in    = '0;
         quo_in    = dividend;
         dsr_in    = divisor;
         cnt_in    = CW'(VALUE_WIDTH - 1);
         active_in = 1'b1;
      end else if (active_ff) begin
         rem_in = take ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
         quo_in = {quo_ff[VALUE_WIDTH-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// File: src/fraction_reduce_top.sv
// fraction_reduce_top: reduces an unsigned fraction to lowest terms.
// Binary GCD with one shared subtractor, then two passes through frd_divider.
// Sequence: a zero numerator or denominator is answered directly from idle; otherwise
//   common twos are stripped, the GCD shift/subtract loop runs, then both divider passes.
// One request at a time, taken while busy is low; the response strobe cannot be stalled.
// Synchronous reset clears the sequencer and the response strobe.
`default_nettype none
module fraction_reduce_top #(
   parameter int VALUE_WIDTH = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire [VALUE_WIDTH-1:0]  req_numerator,
   input  wire [VALUE_WIDTH-1:0]  req_denominator,
   output logic                   rsp_valid,
   output logic [VALUE_WIDTH-1:0] rsp_reduced_numerator,
   output logic [VALUE_WIDTH-1:0] rsp_reduced_denominator
);

   localparam int CW = $clog2(VALUE_WIDTH);

   frd_pkg::state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] num_ff, num_in;
   logic [VALUE_WIDTH-1:0] den_ff, den_in;
   logic [VALUE_WIDTH-1:0] a_ff, a_in;
   logic [VALUE_WIDTH-1:0] b_ff, b_in;
   logic [VALUE_WIDTH-1:0] g_ff, g_in;
   logic [CW-1:0]          k_ff, k_in;
   logic [VALUE_WIDTH-1:0] rnum_ff, rnum_in;
   logic [VALUE_WIDTH-1:0] rden_ff, rden_in;
   logic                   valid_ff, valid_in;

   logic [VALUE_WIDTH:0]   diff;
   logic [VALUE_WIDTH:0]   ndiff;
   logic                   gcd_done;
   logic [VALUE_WIDTH-1:0] gcd_value;

   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [VALUE_WIDTH-1:0] div_divisor;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quotient;

   frd_divider #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      diff      = {1'b0, a_ff} - {1'b0, b_ff};
      ndiff     = -diff;
      gcd_done  = (a_ff == '0) || (b_ff == '0);
      gcd_value = (a_ff | b_ff) << k_ff;

      state_in  = state_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      g_in      = g_ff;
      k_in      = k_ff;
      rnum_in   = rnum_ff;
      rden_in   = rden_ff;
      valid_in  = 1'b0;
      div_start    = 1'b0;
      div_dividend = num_ff;
      div_divisor  = g_ff;

      unique case (state_ff)
         frd_pkg::ST_IDLE: begin
            if (start) begin
               num_in = req_numerator;
               den_in = req_denominator;
               a_in   = req_numerator;
               b_in   = req_denominator;
               k_in   = '0;
               if ((req_numerator == '0) || (req_denominator == '0)) begin
                  rnum_in  = req_numerator;
                  rden_in  = req_denominator;
                  valid_in = 1'b1;
               end else begin
                  state_in = frd_pkg::ST_TWOS;
               end
            end
         end
         frd_pkg::ST_TWOS: begin
            if (a_ff[0] || b_ff[0]) begin
               state_in = frd_pkg::ST_GCD;
            end else begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end
         end
         frd_pkg::ST_GCD: begin
            priority if (gcd_done) begin
               g_in         = gcd_value;
               div_start    = 1'b1;
               div_dividend = num_ff;
               div_divisor  = gcd_value;
               state_in     = frd_pkg::ST_DIVN;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (!diff[VALUE_WIDTH]) begin
               a_in = diff[VALUE_WIDTH:1];
            end else begin
               b_in = ndiff[VALUE_WIDTH:1];
            end
         end
         frd_pkg::ST_DIVN: begin
            if (div_done) begin
               rnum_in      = div_quotient;
               div_start    = 1'b1;
               div_dividend = den_ff;
               div_divisor  = g_ff;
               state_in     = frd_pkg::ST_DIVD;
            end
         end
         frd_pkg::ST_DIVD: begin
            if (div_done) begin
               rden_in  = div_quotient;
               valid_in = 1'b1;
               state_in = frd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      g_ff    <= g_in;
      k_ff    <= k_in;
      rnum_ff <= rnum_in;
      rden_ff <= rden_in;
      if (reset) begin
         state_ff <= frd_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy                    = (state_ff != frd_pkg::ST_IDLE);
   assign rsp_valid               = valid_ff;
   assign rsp_reduced_numerator   = rnum_ff;
   assign rsp_reduced_denominator = rden_ff;

endmodule
`default_nettype wire
